@@ rtl/cfes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfes_pkg
// Shared types and constants of the cooldown first-eligible scheduler.
// ----------------------------------------------------------------------------
package cfes_pkg;

    // Default number of requesters held in the entry RAM
    localparam int MAX_FIELDS_DEF = 16;

    // Field widths
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;
    localparam int DEM_W  = 16;
    localparam int GAP_W  = 8;
    localparam int SLOT_W = 16;

    // Slot count beyond which the over-day flag is raised
    localparam logic [SLOT_W-1:0] DAY_SLOTS = 16'd24;
    localparam logic [SLOT_W-1:0] SLOT_MAX  = 16'hFFFF;

    // Register reset values
    localparam logic [CNT_W-1:0] FIELD_COUNT_RST = 5'd5;
    localparam logic [DEM_W-1:0] SERVICE_RST     = 16'd60;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes on the APB port
    localparam int  PADDR_W         = 3;
    localparam logic REG_FIELD_COUNT = 1'b0;
    localparam logic REG_SERVICE     = 1'b1;

    // Input item
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] field_index;
        logic [DEM_W-1:0] demand;
        logic [GAP_W-1:0] gap;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [CNT_W-1:0]  granted_field;
        logic [SLOT_W-1:0] slot_number;
        logic              all_done;
        logic              over_day;
    } t_out_item;

    // One requester entry as stored in the RAM
    typedef struct packed {
        logic [DEM_W-1:0] remaining;
        logic [GAP_W-1:0] cooldown;
        logic [GAP_W-1:0] gap;
    } t_entry;

    // Result of the shared update unit
    typedef struct packed {
        logic [DEM_W-1:0] new_remaining;
        logic [GAP_W-1:0] new_cooldown;
        logic             eligible;
        logic             has_demand;
        logic             new_has_demand;
    } t_upd_res;

endpackage

@@ rtl/cfes_entry_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfes_entry_ram
// Requester entry RAM, one write and one registered read port. A valid bit per
// entry makes an unwritten entry read as zero demand and zero cooldown.
// ----------------------------------------------------------------------------
module cfes_entry_ram
    import cfes_pkg::*;
#(
    parameter int DEPTH = MAX_FIELDS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry         r_mem [DEPTH];
    logic   [DEPTH-1:0] r_valid;
    t_entry         r_rd_data;
    logic           r_rd_valid;

    // Write the array and register the read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Track written entries; reset empties the whole store at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ rtl/cfes_update_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfes_update_unit
// Shared per-entry arithmetic: eligibility test, saturating demand subtract
// and cooldown reload or countdown.
// ----------------------------------------------------------------------------
module cfes_update_unit
    import cfes_pkg::*;
(
    input  t_entry           i_entry,
    input  logic             i_grant,
    input  logic [DEM_W-1:0] i_service,
    output t_upd_res         o_res
);

    logic [DEM_W-1:0] w_rem;
    logic [GAP_W-1:0] w_cd;

    // Subtract service from the granted entry, saturate at zero
    always_comb begin
        if (!i_grant) begin
            w_rem = i_entry.remaining;
        end else if (i_entry.remaining > i_service) begin
            w_rem = i_entry.remaining - i_service;
        end else begin
            w_rem = '0;
        end
    end

    // Reload the granted cooldown with its gap, count the others down
    always_comb begin
        if (i_grant) begin
            w_cd = i_entry.gap;
        end else if (i_entry.cooldown != '0) begin
            w_cd = i_entry.cooldown - GAP_W'(1);
        end else begin
            w_cd = '0;
        end
    end

    assign o_res.new_remaining  = w_rem;
    assign o_res.new_cooldown   = w_cd;
    assign o_res.has_demand     = (i_entry.remaining != '0);
    assign o_res.eligible       = (i_entry.remaining != '0) && (i_entry.cooldown == '0);
    assign o_res.new_has_demand = (w_rem != '0);

endmodule

@@ rtl/cooldown_first_eligible_scheduler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooldown_first_eligible_scheduler_core
// Requester scheduler that grants the lowest-numbered requester whose cooldown
// has expired and whose demand is not yet served.
// ----------------------------------------------------------------------------
// A load item never produces a result. A tick item keeps the input stalled
// until the edge that puts its result in the output register. The entry RAM
// has one read port and a single update unit, so the sequencer walks the n
// requesters in use (at most MAX_FIELDS) once to find demand and the first
// eligible requester, then once more to write back demand and cooldowns.
// Each pass makes its n reads, takes the last read data and then closes the
// pass; the result is then handed to the output register. A tick that finds
// no demand left skips the second pass. Input stall is high for the whole
// tick; a result that is not taken holds the block in its last state until
// the output register is free, which lengthens the tick. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module cooldown_first_eligible_scheduler_core
    import cfes_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int CW = $clog2(MAX_FIELDS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic              r_any, n_any;
    logic              r_found, n_found;
    logic [IW-1:0]     r_grant, n_grant;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_out_item         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;
    logic [CNT_W-1:0]  r_field_count;
    logic [DEM_W-1:0]  r_service;

    logic [CW-1:0]     w_n;
    logic              w_rd_en;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_addr;
    t_entry            w_wr_data;
    t_entry            w_rd_data;
    logic              w_upd_grant;
    t_upd_res          w_upd;
    logic              w_in_take;
    logic              w_out_take;
    logic              w_cfg_wr;
    logic              w_load_ok;
    logic [SLOT_W-1:0] w_slot_inc;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= FIELD_COUNT_RST;
            r_service     <= SERVICE_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_FIELD_COUNT: r_field_count <= pwdata[CNT_W-1:0];
                REG_SERVICE:     r_service     <= pwdata[DEM_W-1:0];
                default:         r_field_count <= r_field_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FIELD_COUNT: prdata = 32'(r_field_count);
            REG_SERVICE:     prdata = 32'(r_service);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Entry store and shared update unit
    // ------------------------------------------------------------------
    cfes_entry_ram #(
        .DEPTH (MAX_FIELDS),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_upd_grant = (r_state == S_UPD) && r_found && (r_pidx == r_grant);

    cfes_update_unit u_upd (
        .i_entry   (w_rd_data),
        .i_grant   (w_upd_grant),
        .i_service (r_service),
        .o_res     (w_upd)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    // Clamp the active requester count to the store depth
    always_comb begin
        if (32'(r_field_count) > 32'(MAX_FIELDS)) begin
            w_n = CW'(MAX_FIELDS);
        end else begin
            w_n = CW'(r_field_count);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_load_ok  = (32'(i_in_item.field_index) < 32'(MAX_FIELDS));
    assign w_rd_en    = ((r_state == S_SCAN) || (r_state == S_UPD)) && (r_idx < w_n);
    assign w_slot_inc = (r_slot == SLOT_MAX) ? r_slot : r_slot + SLOT_W'(1);

    // Write port: loads while idle, write-back during the update pass
    always_comb begin
        if (r_state == S_UPD) begin
            w_wr_en             = r_pend;
            w_wr_addr           = r_pidx;
            w_wr_data.remaining = w_upd.new_remaining;
            w_wr_data.cooldown  = w_upd.new_cooldown;
            w_wr_data.gap       = w_rd_data.gap;
        end else begin
            w_wr_en             = w_in_take && (i_in_item.cmd == CMD_LOAD) && w_load_ok;
            w_wr_addr           = IW'(i_in_item.field_index);
            w_wr_data.remaining = i_in_item.demand;
            w_wr_data.cooldown  = '0;
            w_wr_data.gap       = i_in_item.gap;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_idx[IW-1:0];
        n_any       = r_any;
        n_found     = r_found;
        n_grant     = r_grant;
        n_slot      = r_slot;
        n_res       = r_res;
        n_out_valid = r_out_valid && !w_out_take;
        n_out_item  = r_out_item;

        // Advance the read pointer one entry a cycle
        if (w_rd_en) begin
            n_idx  = r_idx + CW'(1);
            n_pend = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    if (i_in_item.cmd == CMD_TICK) begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        n_any   = 1'b0;
                        n_found = 1'b0;
                    end else if (w_load_ok) begin
                        n_slot = '0;
                    end
                end
            end
            S_SCAN: begin
                // Note demand and the first eligible requester
                if (r_pend) begin
                    if (w_upd.has_demand) begin
                        n_any = 1'b1;
                    end
                    if (w_upd.eligible && !r_found) begin
                        n_found = 1'b1;
                        n_grant = r_pidx;
                    end
                end
                if (!w_rd_en && !r_pend) begin
                    if (r_any) begin
                        n_state = S_UPD;
                        n_idx   = '0;
                        n_any   = 1'b0;
                    end else begin
                        n_res.granted_field = '0;
                        n_res.slot_number   = r_slot;
                        n_res.all_done      = 1'b1;
                        n_res.over_day      = (r_slot > DAY_SLOTS);
                        n_state             = S_DONE;
                    end
                end
            end
            S_UPD: begin
                // Collect demand left after the write-back
                if (r_pend && w_upd.new_has_demand) begin
                    n_any = 1'b1;
                end
                if (!w_rd_en && !r_pend) begin
                    n_slot              = w_slot_inc;
                    n_res.granted_field = r_found ? CNT_W'(r_grant) + CNT_W'(1) : '0;
                    n_res.slot_number   = r_slot;
                    n_res.all_done      = !r_any;
                    n_res.over_day      = (w_slot_inc > DAY_SLOTS);
                    n_state             = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (!r_out_valid || w_out_take) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_any       <= 1'b0;
            r_found     <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_any       <= n_any;
            r_found     <= n_found;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_grant    <= n_grant;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/cfes_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfes_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module cfes_checker
    import cfes_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    // A tick keeps the input stalled while it is worked on
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.cmd == CMD_TICK) |=> o_in_stall)
        else $error("tick accepted without going busy");

    // A new result only appears at the end of a tick
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a tick in progress");

    // A slot past the day limit always carries the over-day flag
    a_over_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.slot_number > DAY_SLOTS) |-> o_out_item.over_day)
        else $error("over-day flag missing");

endmodule

bind cooldown_first_eligible_scheduler_core cfes_checker u_cfes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ verif/cooldown_first_eligible_scheduler_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooldown_first_eligible_scheduler_core_test
// Self-checking bench for the cooldown first-eligible scheduler. A directed
// table covers reset values, extremes and the corner cases of the grant rule.
// Random load/tick sequences follow under changing settings and idling. Every
// result is checked against its table row or else a scheduling predictor.
// ----------------------------------------------------------------------------
module cooldown_first_eligible_scheduler_core_test;
    import cfes_pkg::*;

    localparam int SETTLE_CYCLES = 2 * MAX_FIELDS_DEF + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int BLOCK_ITEMS   = 100;
    localparam int IN_W          = $bits(t_in_item);
    localparam logic [PADDR_W-1:0] ADDR_FIELD_COUNT = {REG_FIELD_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SERVICE     = {REG_SERVICE, 2'b00};

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_TICK, ROW_TICK_EXP} t_row_kind;

    // cfg: a = address, b = data; load: a = index, b = demand, c = gap;
    // typed tick: a = granted, b = slot, c = all done, d = over day
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_item;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // scheduler state as the bench sees it
    logic [DEM_W-1:0]  need_left [MAX_FIELDS_DEF];
    logic [GAP_W-1:0]  wait_left [MAX_FIELDS_DEF];
    logic [GAP_W-1:0]  gap_len   [MAX_FIELDS_DEF];
    logic [SLOT_W-1:0] slot_cnt = '0;
    logic [CNT_W-1:0]  sched_count = FIELD_COUNT_RST;
    logic [DEM_W-1:0]  sched_service = SERVICE_RST;

    t_out_item pending_grants[$];
    t_row      plan[$];
    int        mismatch_count = 0;
    int        idle_phase = 0;
    int        hold_req_cnt = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    cooldown_first_eligible_scheduler_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < MAX_FIELDS_DEF; i++) begin
            need_left[i] = '0;
            wait_left[i] = '0;
            gap_len[i]   = '0;
        end
    end

    // True when any requester in use still has demand
    function automatic bit demand_pending(input int n);
        for (int i = 0; i < n; i++)
            if (need_left[i] != '0)
                return 1'b1;
        return 1'b0;
    endfunction

    // Advance the scheduler by one accepted item and queue a grant report per tick
    function automatic void predict_grant(input t_in_item it, input bit typed,
                                          input t_out_item typed_res);
        int        n;
        int        first;
        t_out_item res;
        n = (sched_count > MAX_FIELDS_DEF) ? MAX_FIELDS_DEF : int'(sched_count);
        if (it.cmd == CMD_LOAD) begin
            need_left[it.field_index] = it.demand;
            gap_len[it.field_index]   = it.gap;
            wait_left[it.field_index] = '0;
            slot_cnt = '0;
            return;
        end
        res = '0;
        res.slot_number = slot_cnt;
        first = -1;
        if (demand_pending(n)) begin
            for (int i = 0; i < n; i++)
                if (first < 0 && wait_left[i] == '0 && need_left[i] != '0)
                    first = i;
            if (first >= 0) begin
                need_left[first] = (need_left[first] > sched_service) ?
                                   need_left[first] - sched_service : '0;
                wait_left[first] = gap_len[first];
                res.granted_field = CNT_W'(first + 1);
            end
            for (int i = 0; i < n; i++)
                if (i != first && wait_left[i] != '0)
                    wait_left[i] = wait_left[i] - 1'b1;
            if (slot_cnt != SLOT_MAX)
                slot_cnt = slot_cnt + 1'b1;
        end
        res.all_done = !demand_pending(n);
        res.over_day = (slot_cnt > DAY_SLOTS);
        pending_grants.push_back(typed ? typed_res : res);
    endfunction

    // Offer one item, idling first as the phase asks, and predict it on accept
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        int idle_pct;
        idle_pct = (idle_phase == 0) ? 18 : (idle_phase == 1) ? 75 : 0;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_grant(it, typed, typed_res);
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_grants.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, then the bus returns to idle
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FIELD_COUNT)
            sched_count = data[CNT_W-1:0];
        else if (addr == ADDR_SERVICE)
            sched_service = data[DEM_W-1:0];
        @(posedge i_clk);
    endtask

    // Mostly well-formed bursts of loads followed by ticks, some raw noise
    task automatic random_items(input int count);
        t_in_item it;
        int       sent;
        int       lim;
        int       nload;
        int       nticks;
        int       pick;
        sent = 0;
        lim = (sched_count == 0 || sched_count > MAX_FIELDS_DEF) ?
              MAX_FIELDS_DEF : int'(sched_count);
        while (sent < count) begin
            if ($urandom_range(99) < 85) begin
                nload = $urandom_range(1, 4);
                for (int j = 0; j < nload; j++) begin
                    it = IN_W'($urandom);
                    it.cmd = CMD_LOAD;
                    if ($urandom_range(9) == 0)
                        it.field_index = IDX_W'($urandom_range(15));
                    else
                        it.field_index = IDX_W'($urandom_range(lim - 1));
                    pick = $urandom_range(9);
                    if (pick == 0)
                        it.demand = '0;
                    else if (pick < 3)
                        it.demand = DEM_W'($urandom);
                    else
                        it.demand = DEM_W'($urandom_range(1, 400));
                    if ($urandom_range(9) < 8)
                        it.gap = GAP_W'($urandom_range(3));
                    send_item(it, 1'b0, '0);
                    sent++;
                end
                nticks = $urandom_range(1, 40);
                for (int j = 0; j < nticks; j++) begin
                    it = IN_W'($urandom);
                    it.cmd = CMD_TICK;
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end else begin
                it = IN_W'($urandom);
                send_item(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver: a requested long hold-off first, else random stalls per phase
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen   <= hold_req_cnt;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_phase == 0) begin
            i_out_stall <= ($urandom_range(99) < 75);
        end else if (idle_phase == 1) begin
            i_out_stall <= ($urandom_range(99) < 18);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: granted %0d slot %0d done %0b over %0b",
                             o_out_item.granted_field, o_out_item.slot_number,
                             o_out_item.all_done, o_out_item.over_day);
            end else begin
                want = pending_grants.pop_front();
                if (o_out_item.granted_field !== want.granted_field ||
                    o_out_item.slot_number !== want.slot_number ||
                    o_out_item.all_done !== want.all_done ||
                    o_out_item.over_day !== want.over_day) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch: expected granted %0d slot %0d ",
                                  "done %0b over %0b, got granted %0d slot %0d ",
                                  "done %0b over %0b"},
                                 want.granted_field, want.slot_number,
                                 want.all_done, want.over_day,
                                 o_out_item.granted_field, o_out_item.slot_number,
                                 o_out_item.all_done, o_out_item.over_day);
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_in_item    it;
        t_out_item   typed_res;
        logic [31:0] wdata;
        int          pick;

        // Directed table, starting from reset values (5 in use, service 60)
        plan.push_back('{ROW_TICK_EXP, 0, 0, 1, 0});
        plan.push_back('{ROW_LOAD, 0, 100, 2, 0});
        plan.push_back('{ROW_TICK_EXP, 1, 0, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 0, 1, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 0, 2, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 1, 3, 1, 0});
        // no demand left: slot number repeats
        plan.push_back('{ROW_TICK_EXP, 0, 4, 1, 0});
        // load above field count is stored but not scheduled
        plan.push_back('{ROW_LOAD, 15, 65535, 255, 0});
        plan.push_back('{ROW_TICK_EXP, 0, 0, 1, 0});
        plan.push_back('{ROW_CFG, ADDR_FIELD_COUNT, 16, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 16, 0, 0, 0});
        plan.push_back('{ROW_CFG, ADDR_SERVICE, 65535, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 0, 1, 0, 0});
        // field count above the maximum acts as the maximum
        plan.push_back('{ROW_CFG, ADDR_FIELD_COUNT, 31, 0, 0});
        plan.push_back('{ROW_LOAD, 3, 1, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 4, 0, 0, 0});
        plan.push_back('{ROW_TICK, 0, 0, 0, 0});
        // no requester in use
        plan.push_back('{ROW_CFG, ADDR_FIELD_COUNT, 0, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 0, 2, 1, 0});
        // zero service amount, zero gap: grant on every tick, never done
        plan.push_back('{ROW_CFG, ADDR_SERVICE, 0, 0, 0});
        plan.push_back('{ROW_CFG, ADDR_FIELD_COUNT, 1, 0, 0});
        plan.push_back('{ROW_LOAD, 0, 65535, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 1, 0, 0, 0});
        plan.push_back('{ROW_TICK_EXP, 1, 1, 0, 0});
        plan.push_back('{ROW_LOAD, 0, 0, 1, 0});
        plan.push_back('{ROW_TICK_EXP, 0, 0, 1, 0});

        // Hold reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (plan[k]) begin
            it = '0;
            typed_res = '0;
            case (plan[k].kind)
                ROW_CFG: begin
                    wait_idle();
                    reg_write(plan[k].a[PADDR_W-1:0], plan[k].b);
                end
                ROW_LOAD: begin
                    it.cmd         = CMD_LOAD;
                    it.field_index = plan[k].a[IDX_W-1:0];
                    it.demand      = plan[k].b[DEM_W-1:0];
                    it.gap         = plan[k].c[GAP_W-1:0];
                    send_item(it, 1'b0, typed_res);
                end
                ROW_TICK: begin
                    it.cmd = CMD_TICK;
                    send_item(it, 1'b0, typed_res);
                end
                default: begin
                    it.cmd = CMD_TICK;
                    typed_res.granted_field = plan[k].a[CNT_W-1:0];
                    typed_res.slot_number   = plan[k].b[SLOT_W-1:0];
                    typed_res.all_done      = plan[k].c[0];
                    typed_res.over_day      = plan[k].d[0];
                    send_item(it, 1'b1, typed_res);
                end
            endcase
        end

        // Random blocks, new settings before each, three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            idle_phase = phase;
            for (int blk = 0; blk < 4; blk++) begin
                wait_idle();
                pick = $urandom_range(99);
                wdata = $urandom;
                if (pick < 80)
                    wdata[CNT_W-1:0] = CNT_W'($urandom_range(1, MAX_FIELDS_DEF));
                else if (pick < 90)
                    wdata[CNT_W-1:0] = '0;
                else
                    wdata[CNT_W-1:0] = CNT_W'($urandom_range(MAX_FIELDS_DEF + 1, 31));
                reg_write(ADDR_FIELD_COUNT, wdata);
                pick = $urandom_range(99);
                wdata = $urandom;
                if (pick < 60)
                    wdata[DEM_W-1:0] = DEM_W'($urandom_range(1, 200));
                else if (pick < 80)
                    wdata[DEM_W-1:0] = DEM_W'($urandom_range(1, 65535));
                else if (pick < 90)
                    wdata[DEM_W-1:0] = '0;
                else
                    wdata[DEM_W-1:0] = SLOT_MAX;
                reg_write(ADDR_SERVICE, wdata);
                // long receiver hold-off so the block backs up into its input
                if (blk == 1 && phase != 1)
                    hold_req_cnt <= hold_req_cnt + 1;
                random_items(BLOCK_ITEMS);
            end
        end

        // Drain and report
        wait_idle();
        if (mismatch_count == 0 && pending_grants.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
